@@ rtl/core/sstw_pkg.sv @@
// Shared types, command constants and the character-to-segment decoder
// for the two-wire seven-segment digit writer. No dependencies.

package sstw_pkg;

  // Input item opcodes
  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Display controller command bytes and segment constants
  localparam logic [7:0] CMD_DATA_FIXED = 8'h44;
  localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
  localparam logic [7:0] CMD_CTRL_BASE  = 8'h88;
  localparam logic [7:0] SEG_POINT      = 8'h80;
  localparam logic [7:0] CHAR_BLANK     = 8'h7F;
  localparam logic [7:0] SEG_NONE       = 8'h00;
  localparam logic [2:0] BRIGHT_RESET   = 3'd2;

  localparam logic [7:0] HexGlyph [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
  };

  // Transfer elements, one-hot
  typedef enum logic [9:0] {
    ELEM_START_CMD  = 10'b00_0000_0001,
    ELEM_BYTE_CMD   = 10'b00_0000_0010,
    ELEM_STOP_CMD   = 10'b00_0000_0100,
    ELEM_START_ADDR = 10'b00_0000_1000,
    ELEM_BYTE_ADDR  = 10'b00_0001_0000,
    ELEM_BYTE_SEG   = 10'b00_0010_0000,
    ELEM_STOP_ADDR  = 10'b00_0100_0000,
    ELEM_START_CTRL = 10'b00_1000_0000,
    ELEM_BYTE_CTRL  = 10'b01_0000_0000,
    ELEM_STOP_FINAL = 10'b10_0000_0000
  } elem_e;

  // Classified item passed from front to back
  typedef struct packed {
    logic       mode;
    logic       pos_ok;
    logic [1:0] digit_position;
    logic [7:0] segments;
    logic       dio_in;
  } cmd_t;

  // Map a character code to its segment pattern
  function automatic logic [7:0] glyph(input logic [7:0] c);
    logic [7:0] g;
    g = SEG_NONE;
    if (c == CHAR_BLANK) begin
      g = SEG_NONE;
    end else if (c < 8'd16) begin
      g = HexGlyph[c[3:0]];
    end else if (c >= "0" && c <= "9") begin
      g = HexGlyph[4'(c - 8'h30)];
    end else begin
      unique case (c) inside
        "_":      g = 8'h08;
        "^":      g = 8'h01;
        "-":      g = 8'h40;
        "*":      g = 8'h63;
        "A":      g = 8'h77;
        "a":      g = 8'h5F;
        "B", "b": g = 8'h7C;
        "C":      g = 8'h39;
        "c":      g = 8'h58;
        "D", "d": g = 8'h5E;
        "E", "e": g = 8'h79;
        "F", "f": g = 8'h71;
        "G", "g": g = 8'h35;
        "H":      g = 8'h76;
        "h":      g = 8'h74;
        "I":      g = 8'h06;
        "i":      g = 8'h04;
        "J":      g = 8'h1E;
        "j":      g = 8'h16;
        "K", "k": g = 8'h75;
        "L", "l": g = 8'h38;
        "M", "m": g = 8'h37;
        "N", "n": g = 8'h54;
        "O", "o": g = 8'h5C;
        "P", "p": g = 8'h73;
        "Q":      g = 8'h7B;
        "q":      g = 8'h67;
        "R", "r": g = 8'h50;
        "S", "s": g = 8'h6D;
        "T", "t": g = 8'h78;
        "U", "u": g = 8'h1C;
        "V", "v": g = 8'h3E;
        "W":      g = 8'h7E;
        "w":      g = 8'h2A;
        "X", "x": g = 8'h76;
        "Y", "y": g = 8'h6E;
        "Z", "z": g = 8'h1B;
        default:  g = SEG_NONE;
      endcase
    end
    return g;
  endfunction

endpackage

@@ rtl/core/sstw_in_if.sv @@
// Input channel: valid/ready handshake with the digit write / tick payload.
// No dependencies.

interface sstw_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [1:0] digit_position;
  logic [7:0] char_code;
  logic       point;
  logic       dio_in;

  modport source (output valid, mode, digit_position, char_code, point, dio_in,
                  input ready);
  modport sink   (input valid, mode, digit_position, char_code, point, dio_in,
                  output ready);
endinterface

@@ rtl/core/sstw_out_if.sv @@
// Output channel: valid/ready handshake with pin levels and status flags.
// No dependencies.

interface sstw_out_if;
  logic valid;
  logic ready;
  logic clk_level;
  logic dio_level;
  logic dio_drive;
  logic busy_res;
  logic ack_missing;
  logic done_res;
  logic request_refused;

  modport source (output valid, clk_level, dio_level, dio_drive, busy_res,
                  ack_missing, done_res, request_refused,
                  input ready);
  modport sink   (input valid, clk_level, dio_level, dio_drive, busy_res,
                  ack_missing, done_res, request_refused,
                  output ready);
endinterface

@@ rtl/core/sstw_front.sv @@
// Front end: accepts input transactions, encodes the character and checks
// the digit position. Depends on sstw_pkg and sstw_in_if.

module sstw_front #(
  parameter int DIGIT_COUNT = 4
) (
  sstw_in_if.sink        in_i,
  input  logic           q_ready_i,
  output logic           q_push_o,
  output sstw_pkg::cmd_t q_data_o
);

  localparam logic [2:0] DigitLimit = 3'(DIGIT_COUNT);

  // Take a transaction whenever the queue has room
  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid & q_ready_i;

  // Classify and encode
  always_comb begin
    q_data_o.mode           = in_i.mode;
    q_data_o.pos_ok         = ({1'b0, in_i.digit_position} < DigitLimit);
    q_data_o.digit_position = in_i.digit_position;
    q_data_o.segments       = sstw_pkg::glyph(in_i.char_code)
                              | (in_i.point ? sstw_pkg::SEG_POINT : sstw_pkg::SEG_NONE);
    q_data_o.dio_in         = in_i.dio_in;
  end

endmodule

@@ rtl/core/sstw_queue.sv @@
// Two-entry queue of classified transactions between front and back.
// Depends on sstw_pkg.

module sstw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sstw_pkg::cmd_t data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sstw_pkg::cmd_t data_o
);

  sstw_pkg::cmd_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/core/sstw_back.sv @@
// Back end: pin-phase sequencer for the three framed transfers and the
// registered result stage. Depends on sstw_pkg and sstw_out_if.

module sstw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     brightness_i,
  input  logic           q_valid_i,
  input  sstw_pkg::cmd_t q_data_i,
  output logic           q_pop_o,
  sstw_out_if.source     out_o
);

  sstw_pkg::elem_e elem_q, elem_d, elem_nxt;
  logic [2:0] sub_q, sub_d;
  logic [2:0] bit_q, bit_d, bit_inc;
  logic [7:0] shift_q, shift_d;
  logic [7:0] seg_q, seg_d;
  logic [1:0] addr_q, addr_d;
  logic       busy_q, busy_d;
  logic       clk_q, clk_d;
  logic       dio_q, dio_d;
  logic       en_q, en_d;
  logic       load_next;
  logic       ack_miss, done, refused;

  logic       out_valid_q;
  logic       ack_q, done_q, refused_q;

  // Pop when the result register is free or being taken
  assign q_pop_o = q_valid_i & (~out_valid_q | out_o.ready);
  assign bit_inc = bit_q + 3'd1;

  // Element order
  always_comb begin
    unique case (elem_q)
      sstw_pkg::ELEM_START_CMD:  elem_nxt = sstw_pkg::ELEM_BYTE_CMD;
      sstw_pkg::ELEM_BYTE_CMD:   elem_nxt = sstw_pkg::ELEM_STOP_CMD;
      sstw_pkg::ELEM_STOP_CMD:   elem_nxt = sstw_pkg::ELEM_START_ADDR;
      sstw_pkg::ELEM_START_ADDR: elem_nxt = sstw_pkg::ELEM_BYTE_ADDR;
      sstw_pkg::ELEM_BYTE_ADDR:  elem_nxt = sstw_pkg::ELEM_BYTE_SEG;
      sstw_pkg::ELEM_BYTE_SEG:   elem_nxt = sstw_pkg::ELEM_STOP_ADDR;
      sstw_pkg::ELEM_STOP_ADDR:  elem_nxt = sstw_pkg::ELEM_START_CTRL;
      sstw_pkg::ELEM_START_CTRL: elem_nxt = sstw_pkg::ELEM_BYTE_CTRL;
      sstw_pkg::ELEM_BYTE_CTRL:  elem_nxt = sstw_pkg::ELEM_STOP_FINAL;
      default:                   elem_nxt = sstw_pkg::ELEM_START_CMD;
    endcase
  end

  // Step the sequencer for one transaction
  always_comb begin
    elem_d    = elem_q;
    sub_d     = sub_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    seg_d     = seg_q;
    addr_d    = addr_q;
    busy_d    = busy_q;
    clk_d     = clk_q;
    dio_d     = dio_q;
    en_d      = en_q;
    load_next = 1'b0;
    ack_miss  = 1'b0;
    done      = 1'b0;
    refused   = 1'b0;

    if (q_pop_o) begin
      if (q_data_i.mode == sstw_pkg::MODE_WRITE) begin
        if (busy_q || !q_data_i.pos_ok) begin
          refused = 1'b1;
        end else begin
          addr_d = q_data_i.digit_position;
          seg_d  = q_data_i.segments;
          busy_d = 1'b1;
          elem_d = sstw_pkg::ELEM_START_CMD;
          sub_d  = 3'd0;
          bit_d  = 3'd0;
        end
      end else if (busy_q) begin
        unique case (elem_q) inside
          sstw_pkg::ELEM_START_CMD, sstw_pkg::ELEM_START_ADDR,
          sstw_pkg::ELEM_START_CTRL: begin
            if (sub_q == 3'd0) begin
              clk_d = 1'b1;
              dio_d = 1'b1;
              en_d  = 1'b1;
              sub_d = sub_q + 3'd1;
            end else if (sub_q == 3'd1) begin
              dio_d = 1'b0;
              en_d  = 1'b1;
              sub_d = sub_q + 3'd1;
            end else begin
              clk_d     = 1'b0;
              load_next = 1'b1;
            end
          end
          sstw_pkg::ELEM_STOP_CMD, sstw_pkg::ELEM_STOP_ADDR,
          sstw_pkg::ELEM_STOP_FINAL: begin
            if (sub_q == 3'd0) begin
              clk_d = 1'b0;
              sub_d = sub_q + 3'd1;
            end else if (sub_q == 3'd1) begin
              dio_d = 1'b0;
              en_d  = 1'b1;
              sub_d = sub_q + 3'd1;
            end else if (sub_q == 3'd2) begin
              clk_d = 1'b1;
              sub_d = sub_q + 3'd1;
            end else begin
              dio_d = 1'b1;
              en_d  = 1'b1;
              if (elem_q == sstw_pkg::ELEM_STOP_FINAL) begin
                // Final stop: drop back to idle
                done   = 1'b1;
                elem_d = sstw_pkg::ELEM_START_CMD;
                sub_d  = 3'd0;
                bit_d  = 3'd0;
                busy_d = 1'b0;
                clk_d  = 1'b1;
              end else begin
                load_next = 1'b1;
              end
            end
          end
          sstw_pkg::ELEM_BYTE_CMD, sstw_pkg::ELEM_BYTE_ADDR,
          sstw_pkg::ELEM_BYTE_SEG, sstw_pkg::ELEM_BYTE_CTRL: begin
            if (sub_q == 3'd0) begin
              clk_d = 1'b0;
              en_d  = 1'b1;
              dio_d = shift_q[0];
              sub_d = sub_q + 3'd1;
            end else if (sub_q == 3'd1) begin
              // Clock the bit out, repeat until all eight are sent
              clk_d   = 1'b1;
              shift_d = {1'b0, shift_q[7:1]};
              bit_d   = bit_inc;
              sub_d   = (bit_inc == 3'd0) ? 3'd2 : 3'd0;
            end else if (sub_q == 3'd2) begin
              clk_d = 1'b0;
              dio_d = 1'b1;
              en_d  = 1'b1;
              sub_d = sub_q + 3'd1;
            end else if (sub_q == 3'd3) begin
              clk_d = 1'b1;
              en_d  = 1'b0;
              sub_d = sub_q + 3'd1;
            end else begin
              // Sample the acknowledge and drive it back
              ack_miss  = q_data_i.dio_in;
              dio_d     = q_data_i.dio_in;
              en_d      = 1'b1;
              load_next = 1'b1;
            end
          end
          default: begin
            elem_d = sstw_pkg::ELEM_START_CMD;
            sub_d  = 3'd0;
            bit_d  = 3'd0;
            busy_d = 1'b0;
            clk_d  = 1'b1;
            dio_d  = 1'b1;
            en_d   = 1'b1;
          end
        endcase
      end
    end

    // Enter the next element and preload its byte
    if (load_next) begin
      elem_d = elem_nxt;
      sub_d  = 3'd0;
      bit_d  = 3'd0;
      unique case (elem_nxt)
        sstw_pkg::ELEM_BYTE_CMD:  shift_d = sstw_pkg::CMD_DATA_FIXED;
        sstw_pkg::ELEM_BYTE_ADDR: shift_d = sstw_pkg::CMD_ADDR_BASE | {6'd0, addr_q};
        sstw_pkg::ELEM_BYTE_SEG:  shift_d = seg_q;
        sstw_pkg::ELEM_BYTE_CTRL: shift_d = sstw_pkg::CMD_CTRL_BASE + {5'd0, brightness_i};
        default:                  shift_d = shift_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q  <= sstw_pkg::ELEM_START_CMD;
      sub_q   <= 3'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      seg_q   <= 8'd0;
      addr_q  <= 2'd0;
      busy_q  <= 1'b0;
      clk_q   <= 1'b1;
      dio_q   <= 1'b1;
      en_q    <= 1'b1;
    end else begin
      elem_q  <= elem_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      seg_q   <= seg_d;
      addr_q  <= addr_d;
      busy_q  <= busy_d;
      clk_q   <= clk_d;
      dio_q   <= dio_d;
      en_q    <= en_d;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ack_q     <= ack_miss;
      done_q    <= done;
      refused_q <= refused;
    end
  end

  // Pin levels and busy follow the state registers directly
  assign out_o.valid           = out_valid_q;
  assign out_o.clk_level       = clk_q;
  assign out_o.dio_level       = dio_q;
  assign out_o.dio_drive       = en_q;
  assign out_o.busy_res        = busy_q;
  assign out_o.ack_missing     = ack_q;
  assign out_o.done_res        = done_q;
  assign out_o.request_refused = refused_q;

endmodule

@@ rtl/core/seven_segment_two_wire_digit_writer.sv @@
// An accepted transaction passes through the two-entry queue and then the registered result stage.
// Throughput: one transaction per cycle while the result register is free or being taken;
// the two-entry queue lets input and output stall independently.
// Reset (async, active low): idle, lines high and driven, brightness 2,
// queue and result register empty.
// Depends on sstw_pkg, sstw_in_if, sstw_out_if, sstw_front, sstw_queue, sstw_back.

module seven_segment_two_wire_digit_writer #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  sstw_in_if.sink    in_i,
  sstw_out_if.source out_o
);

  logic [2:0]     bright_q;
  logic           q_push, q_ready, q_pop, q_valid;
  sstw_pkg::cmd_t q_wdata, q_rdata;

  // Brightness register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= sstw_pkg::BRIGHT_RESET;
    end else if (cfg_we_i) begin
      bright_q <= cfg_wdata_i;
    end
  end

  sstw_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  sstw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  sstw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .brightness_i (bright_q),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_o        (out_o)
  );

endmodule

@@ rtl/core/sstw_checker.sv @@
// Port-level checks on the result channel of the digit writer, bound to
// the top level. Depends on seven_segment_two_wire_digit_writer.

module sstw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic valid_i,
  input logic ready_i,
  input logic dio_level_i,
  input logic dio_drive_i,
  input logic busy_i,
  input logic ack_missing_i,
  input logic done_i,
  input logic refused_i
);

  // A waiting result holds
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("result dropped while stalled");

  // The final stop leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && done_i |-> !busy_i && dio_drive_i && dio_level_i)
    else $error("done reported while still busy");

  // A refused write and the end of a transfer come from different items
  a_refuse_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !(refused_i && done_i))
    else $error("refused and done in one result");

  // A missing acknowledge is driven back high mid-transfer
  a_ack_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ack_missing_i |-> busy_i && dio_drive_i && dio_level_i)
    else $error("ack flag inconsistent with pins");

endmodule

bind seven_segment_two_wire_digit_writer sstw_checker u_sstw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (out_o.valid),
  .ready_i       (out_o.ready),
  .dio_level_i   (out_o.dio_level),
  .dio_drive_i   (out_o.dio_drive),
  .busy_i        (out_o.busy_res),
  .ack_missing_i (out_o.ack_missing),
  .done_i        (out_o.done_res),
  .refused_i     (out_o.request_refused)
);

@@ sim/seven_segment_two_wire_digit_writer_check.sv @@
// Checker for the two-wire seven-segment digit writer: mirrors the pin sequencer
// for every accepted input transaction and compares output transactions in order.
// Depends on sstw_pkg, sstw_in_if and sstw_out_if.

module seven_segment_two_wire_digit_writer_check #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  sstw_in_if         in_i,
  sstw_out_if        out_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Frame elements in transfer order; the sequencer step holds element * 16 + sub-phase
  typedef enum logic [3:0] {
    FE_START_CMD, FE_BYTE_CMD, FE_STOP_CMD,
    FE_START_ADDR, FE_BYTE_ADDR, FE_BYTE_SEG, FE_STOP_ADDR,
    FE_START_CTRL, FE_BYTE_CTRL, FE_STOP_FINAL
  } frame_elem_e;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic ack_missing;
    logic done_res;
    logic request_refused;
  } pins_t;

  logic [2:0] bright;
  logic [7:0] seq_step;
  logic [2:0] bit_idx;
  logic [7:0] tx_byte;
  logic [7:0] seg_byte;
  logic [1:0] grid_addr;
  logic       scl_lvl, sda_lvl, sda_oe, busy;
  pins_t      pin_levels_q[$];
  int         shown;

  function automatic logic [7:0] hex_segments(input logic [3:0] d);
    case (d)
      4'h0: return 8'h3F;
      4'h1: return 8'h06;
      4'h2: return 8'h5B;
      4'h3: return 8'h4F;
      4'h4: return 8'h66;
      4'h5: return 8'h6D;
      4'h6: return 8'h7D;
      4'h7: return 8'h07;
      4'h8: return 8'h7F;
      4'h9: return 8'h6F;
      4'hA: return 8'h77;
      4'hB: return 8'h7C;
      4'hC: return 8'h39;
      4'hD: return 8'h5E;
      4'hE: return 8'h79;
      default: return 8'h71;
    endcase
  endfunction

  // Character code to segment pattern; anything unlisted lights nothing
  function automatic logic [7:0] segments_for(input logic [7:0] c);
    if (c == sstw_pkg::CHAR_BLANK) return sstw_pkg::SEG_NONE;
    if (c < 8'd16) return hex_segments(c[3:0]);
    if (c >= "0" && c <= "9") return hex_segments(4'(c - "0"));
    case (c)
      "_":      return 8'h08;
      "^":      return 8'h01;
      "-":      return 8'h40;
      "*":      return 8'h63;
      "A":      return 8'h77;
      "a":      return 8'h5F;
      "B", "b": return 8'h7C;
      "C":      return 8'h39;
      "c":      return 8'h58;
      "D", "d": return 8'h5E;
      "E", "e": return 8'h79;
      "F", "f": return 8'h71;
      "G", "g": return 8'h35;
      "H":      return 8'h76;
      "h":      return 8'h74;
      "I":      return 8'h06;
      "i":      return 8'h04;
      "J":      return 8'h1E;
      "j":      return 8'h16;
      "K", "k": return 8'h75;
      "L", "l": return 8'h38;
      "M", "m": return 8'h37;
      "N", "n": return 8'h54;
      "O", "o": return 8'h5C;
      "P", "p": return 8'h73;
      "Q":      return 8'h7B;
      "q":      return 8'h67;
      "R", "r": return 8'h50;
      "S", "s": return 8'h6D;
      "T", "t": return 8'h78;
      "U", "u": return 8'h1C;
      "V", "v": return 8'h3E;
      "W":      return 8'h7E;
      "w":      return 8'h2A;
      "X", "x": return 8'h76;
      "Y", "y": return 8'h6E;
      "Z", "z": return 8'h1B;
      default:  return sstw_pkg::SEG_NONE;
    endcase
  endfunction

  // Release both lines high and driven, drop busy
  function automatic void idle_lines();
    seq_step = 8'd0;
    bit_idx  = 3'd0;
    busy     = 1'b0;
    scl_lvl  = 1'b1;
    sda_lvl  = 1'b1;
    sda_oe   = 1'b1;
  endfunction

  // Advance to the element after e, loading the byte it sends if it is a byte
  function automatic void enter_element(input logic [3:0] e);
    logic [3:0] n;
    n = e + 4'd1;
    seq_step = {n, 4'd0};
    bit_idx  = 3'd0;
    case (n)
      FE_BYTE_CMD:  tx_byte = sstw_pkg::CMD_DATA_FIXED;
      FE_BYTE_ADDR: tx_byte = sstw_pkg::CMD_ADDR_BASE | {6'd0, grid_addr};
      FE_BYTE_SEG:  tx_byte = seg_byte;
      FE_BYTE_CTRL: tx_byte = sstw_pkg::CMD_CTRL_BASE + {5'd0, bright};
      default: ;
    endcase
  endfunction

  // One input transaction: latch a write or advance one pin phase
  function automatic pins_t predict_pins(input logic mode, input logic [1:0] pos,
                                         input logic [7:0] code, input logic pt,
                                         input logic dio);
    pins_t      r;
    logic [3:0] e, sub;
    r = '0;
    e = seq_step[7:4];
    sub = seq_step[3:0];
    if (mode == sstw_pkg::MODE_WRITE) begin
      if (busy || pos >= DIGIT_COUNT) begin
        r.request_refused = 1'b1;
      end else begin
        grid_addr = pos;
        seg_byte  = segments_for(code) | (pt ? sstw_pkg::SEG_POINT : sstw_pkg::SEG_NONE);
        busy      = 1'b1;
        seq_step  = 8'd0;
        bit_idx   = 3'd0;
      end
    end else if (busy) begin
      if (e > FE_STOP_FINAL) begin
        idle_lines();
      end else if (e inside {FE_START_CMD, FE_START_ADDR, FE_START_CTRL}) begin
        // start: both high, data falls, clock falls
        if (sub == 4'd0) begin
          scl_lvl = 1'b1; sda_lvl = 1'b1; sda_oe = 1'b1; seq_step = seq_step + 8'd1;
        end else if (sub == 4'd1) begin
          sda_lvl = 1'b0; sda_oe = 1'b1; seq_step = seq_step + 8'd1;
        end else begin
          scl_lvl = 1'b0;
          enter_element(e);
        end
      end else if (e inside {FE_STOP_CMD, FE_STOP_ADDR, FE_STOP_FINAL}) begin
        // stop: clock low, data low, clock high, data high
        if (sub == 4'd0) begin
          scl_lvl = 1'b0; seq_step = seq_step + 8'd1;
        end else if (sub == 4'd1) begin
          sda_lvl = 1'b0; sda_oe = 1'b1; seq_step = seq_step + 8'd1;
        end else if (sub == 4'd2) begin
          scl_lvl = 1'b1; seq_step = seq_step + 8'd1;
        end else begin
          sda_lvl = 1'b1;
          sda_oe  = 1'b1;
          if (e == FE_STOP_FINAL) begin
            r.done_res = 1'b1;
            idle_lines();
          end else begin
            enter_element(e);
          end
        end
      end else begin
        // byte: eight bits LSB first, then the acknowledge slot
        if (sub == 4'd0) begin
          scl_lvl = 1'b0; sda_oe = 1'b1; sda_lvl = tx_byte[0]; seq_step = seq_step + 8'd1;
        end else if (sub == 4'd1) begin
          scl_lvl  = 1'b1;
          tx_byte  = tx_byte >> 1;
          bit_idx  = bit_idx + 3'd1;
          seq_step = {seq_step[7:4], (bit_idx == 3'd0) ? 4'd2 : 4'd0};
        end else if (sub == 4'd2) begin
          scl_lvl = 1'b0; sda_lvl = 1'b1; sda_oe = 1'b1; seq_step = seq_step + 8'd1;
        end else if (sub == 4'd3) begin
          scl_lvl = 1'b1; sda_oe = 1'b0; seq_step = seq_step + 8'd1;
        end else begin
          r.ack_missing = dio;
          sda_lvl = dio;
          sda_oe  = 1'b1;
          enter_element(e);
        end
      end
    end
    r.clk_level = scl_lvl;
    r.dio_level = sda_lvl;
    r.dio_drive = sda_oe;
    r.busy_res  = busy;
    return r;
  endfunction

  function automatic void flag_failure(input string msg);
    fail_count_o++;
    if (shown < 10) begin
      $display("%0t ns: %s", $realtime, msg);
      shown++;
    end
  endfunction

  // Compare the output transaction first, then queue the prediction for the input one
  always @(posedge clk_i or negedge rst_ni) begin
    pins_t want, got;
    if (!rst_ni) begin
      bright    = sstw_pkg::BRIGHT_RESET;
      tx_byte   = 8'd0;
      seg_byte  = 8'd0;
      grid_addr = 2'd0;
      idle_lines();
      pin_levels_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      shown        = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = {out_i.clk_level, out_i.dio_level, out_i.dio_drive, out_i.busy_res,
               out_i.ack_missing, out_i.done_res, out_i.request_refused};
        if (pin_levels_q.size() == 0) begin
          flag_failure($sformatf("unexpected result %b (clk dio drive busy ackmiss done refused)",
                                 got));
        end else begin
          want = pin_levels_q.pop_front();
          if (got !== want) begin
            flag_failure($sformatf(
              "result mismatch: want %b got %b (clk dio drive busy ackmiss done refused)",
              want, got));
          end
        end
      end
      if (cfg_we_i) begin
        bright = cfg_wdata_i;
      end
      if (in_i.valid && in_i.ready) begin
        pin_levels_q.push_back(predict_pins(in_i.mode, in_i.digit_position, in_i.char_code,
                                            in_i.point, in_i.dio_in));
      end
      pending_o = pin_levels_q.size();
    end
  end

endmodule

@@ sim/seven_segment_two_wire_digit_writer_test.sv @@
// Top of the digit writer testbench: clock, reset, brightness writes and input
// stimulus with random idling; the checker beside the block gives the failure count.
// Depends on sstw_pkg, sstw_in_if, sstw_out_if, the block and its checker.

module seven_segment_two_wire_digit_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS          = 4;
  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int FRAME_TICKS     = 97;   // ticks from a write to the end of its last stop
  localparam int PHASE_ITEMS     = 160;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES     = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we;
  logic [2:0] cfg_wdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int ticks_left;
  int fail_count;
  int pending;
  int hold_left = 0;
  int stalled_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  sstw_in_if  in_ch ();
  sstw_out_if out_ch ();

  seven_segment_two_wire_digit_writer #(.DIGIT_COUNT(DIGITS)) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  seven_segment_two_wire_digit_writer_check #(.DIGIT_COUNT(DIGITS)) pin_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Receiver: random ready, plus one long hold-off once requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one transaction after random idle cycles, hold it until accepted
  task automatic send(input logic mode, input logic [1:0] pos, input logic [7:0] code,
                      input logic pt, input logic dio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= mode;
    in_ch.digit_position <= pos;
    in_ch.char_code      <= code;
    in_ch.point          <= pt;
    in_ch.dio_in         <= dio;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    // track how many ticks the frame in flight still needs
    if (mode == sstw_pkg::MODE_WRITE) begin
      if (ticks_left == 0) ticks_left = FRAME_TICKS;
    end else if (ticks_left > 0) begin
      ticks_left--;
    end
  endtask

  task automatic send_noise_tick();
    send(sstw_pkg::MODE_TICK, 2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(15))
      0:  return sstw_pkg::CHAR_BLANK;
      1:  return 8'd0;
      2:  return 8'd15;
      3:  return "0";
      4:  return "9";
      5:  return "A";
      6:  return "z";
      7:  return "_";
      8:  return "-";
      9:  return 8'd128;
      10: return 8'd255;
      11: return 8'd16;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly whole frames: a write when idle, ticks while busy, few stray writes
  task automatic send_random();
    int roll;
    bit is_write;
    roll = $urandom_range(99);
    is_write = (ticks_left == 0) ? (roll < 75) : (roll < 4);
    if (!is_write) begin
      send_noise_tick();
    end else begin
      send(sstw_pkg::MODE_WRITE, 2'($urandom), (ticks_left == 0) ? pick_char() : 8'($urandom),
           1'($urandom), 1'($urandom));
    end
  endtask

  // Drop valid, wait for every result, then write the brightness register
  task automatic set_brightness(input logic [2:0] level);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= level;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.mode           = sstw_pkg::MODE_TICK;
    in_ch.digit_position = 2'd0;
    in_ch.char_code      = 8'd0;
    in_ch.point          = 1'b0;
    in_ch.dio_in         = 1'b0;
    out_ch.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 3'd0;
    ticks_left           = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 12; recv_idle_pct = 56; end
        1: begin send_idle_pct = 56; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      set_brightness((phase == 0) ? 3'd7 : (phase == 1) ? 3'd0 : 3'($urandom_range(1, 6)));

      if (phase == 0) begin
        // idle ticks with every field at both extremes
        send(sstw_pkg::MODE_TICK, 2'd3, 8'hFF, 1'b1, 1'b1);
        send(sstw_pkg::MODE_TICK, 2'd0, 8'h00, 1'b0, 1'b0);
        // blank digit with point on the last grid, then a write while busy
        send(sstw_pkg::MODE_WRITE, 2'd3, sstw_pkg::CHAR_BLANK, 1'b1, 1'b0);
        send(sstw_pkg::MODE_WRITE, 2'd0, 8'h00, 1'b0, 1'b0);
        // run up to the first acknowledge and leave the line high there
        for (int t = 0; t < 22; t++) begin
          send(sstw_pkg::MODE_TICK, 2'd0, 8'h00, 1'b0, 1'(t == 21));
        end
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 2 && n == 30) hold_req = 1'b1;
        send_random();
      end
      // finish the frame in flight so the block is idle for the next register write
      while (ticks_left > 0) send_noise_tick();
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
